FILE: src/aegis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aegis_pkg
// Shared types, constants and AES round helpers for the AEGIS-128L engine.
// ----------------------------------------------------------------------------
package aegis_pkg;

   localparam int unsigned CntWidth = 61;

   typedef enum logic [2:0] {
      ACT_INIT     = 3'd0,
      ACT_ABSORB   = 3'd1,
      ACT_ENCRYPT  = 3'd2,
      ACT_DECRYPT  = 3'd3,
      ACT_FINAL    = 3'd4,
      ACT_VERIFY   = 3'd5,
      ACT_RSVD6    = 3'd6,
      ACT_RSVD7    = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      CSR_KEY_LOW  = 2'd0,
      CSR_KEY_HIGH = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } ctrl_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;       // capture the input word
      logic start_init; // load key/nonce state
      logic start_fin;  // load tag-round message
      logic step;       // apply one update with the round message
      logic data_step;  // single data update plus output and counts
      logic make_tag;   // compute tag into result
      logic clear_res;  // zero result
   } dp_cmd_type;

   typedef struct packed {
      action_type action;
      logic       data_nonzero;
   } dp_status_type;

   localparam logic [127:0] Const0 = 128'h6279e990_59372215_0d080503_02010100;
   localparam logic [127:0] Const1 = 128'hdd28b573_42311120_f12fc26d_55183ddb;

   localparam logic [7:0] Sbox [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,
      8'hfe,8'hd7,8'hab,8'h76,8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
      8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,8'hb7,8'hfd,8'h93,8'h26,
      8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,
      8'heb,8'h27,8'hb2,8'h75,8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
      8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,8'h53,8'hd1,8'h00,8'hed,
      8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,
      8'h50,8'h3c,8'h9f,8'ha8,8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
      8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,8'hcd,8'h0c,8'h13,8'hec,
      8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,
      8'hde,8'h5e,8'h0b,8'hdb,8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
      8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,8'he7,8'hc8,8'h37,8'h6d,
      8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,
      8'h4b,8'hbd,8'h8b,8'h8a,8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
      8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,8'he1,8'hf8,8'h98,8'h11,
      8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,
      8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] x);
      xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // One AES round; byte i sits at bits [8i+7:8i]
   function automatic logic [127:0] aes_round(input logic [127:0] din,
                                              input logic [127:0] rk);
      logic [127:0] t;
      logic [127:0] o;
      logic [7:0]   a0, a1, a2, a3, al;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[8*(r+4*c) +: 8] = Sbox[din[8*(r + 4*((c + r) % 4)) +: 8]];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[8*(4*c) +: 8];
         a1 = t[8*(4*c+1) +: 8];
         a2 = t[8*(4*c+2) +: 8];
         a3 = t[8*(4*c+3) +: 8];
         al = a0 ^ a1 ^ a2 ^ a3;
         o[8*(4*c) +: 8]   = a0 ^ al ^ xtime(a0 ^ a1);
         o[8*(4*c+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
         o[8*(4*c+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
         o[8*(4*c+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
      end
      aes_round = o ^ rk;
   endfunction

endpackage
`default_nettype wire

FILE: src/aegis_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aegis_ctrl
// Sequencer: counts init and finalize update rounds, drives the handshakes.
// ----------------------------------------------------------------------------
module aegis_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire aegis_pkg::dp_status_type status,
   output aegis_pkg::dp_cmd_type        cmd
);
   import aegis_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic [3:0]     rounds_ff, rounds_in;
   logic           phase_ff, phase_in; // 0: setup cycle, 1: rounds

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rounds_ff <= '0;
         phase_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rounds_ff <= rounds_in;
         phase_ff  <= phase_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      rounds_in = rounds_ff;
      phase_in  = phase_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
               phase_in = 1'b0;
            end
         end
         ST_RUN: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
               case (status.action)
                  ACT_INIT: begin
                     cmd.start_init = 1'b1;
                     rounds_in      = 4'd10;
                  end
                  ACT_FINAL, ACT_VERIFY: begin
                     cmd.start_fin = 1'b1;
                     rounds_in     = 4'd7;
                  end
                  ACT_ABSORB, ACT_ENCRYPT, ACT_DECRYPT: begin
                     cmd.clear_res = 1'b1;
                     if (status.data_nonzero) cmd.data_step = 1'b1;
                     state_in = ST_DONE;
                  end
                  default: begin
                     cmd.clear_res = 1'b1;
                     state_in      = ST_DONE;
                  end
               endcase
            end else begin
               cmd.step  = 1'b1;
               rounds_in = rounds_ff - 4'd1;
               if (rounds_ff == 4'd1) begin
                  state_in = ST_DONE;
                  if (status.action == ACT_FINAL || status.action == ACT_VERIFY)
                     cmd.make_tag = 1'b1;
                  else
                     cmd.clear_res = 1'b1;
               end
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

FILE: src/aegis_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aegis_datapath
// Cipher state, byte counters, eight-lane AES round update and result word.
// ----------------------------------------------------------------------------
module aegis_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire aegis_pkg::dp_cmd_type cmd,
   output aegis_pkg::dp_status_type   status,
   input  wire logic [2:0]            req_action,
   input  wire logic [63:0]           req_data_word0,
   input  wire logic [63:0]           req_data_word1,
   input  wire logic [63:0]           req_data_word2,
   input  wire logic [63:0]           req_data_word3,
   input  wire logic [5:0]            req_valid_bytes,
   input  wire logic                  csr_write,
   input  wire logic [0:0]            csr_index,
   input  wire logic                  csr_index_hi,
   input  wire logic [63:0]           csr_data,
   output logic [63:0]                rsp_out_word0,
   output logic [63:0]                rsp_out_word1,
   output logic [63:0]                rsp_out_word2,
   output logic [63:0]                rsp_out_word3,
   output logic                       rsp_tag_match
);
   import aegis_pkg::*;

   logic [127:0] key_ff;
   logic [127:0] s_ff [8];
   logic [127:0] s_in [8];
   logic [127:0] m0_ff, m1_ff, m0_in, m1_in;
   logic [255:0] blk_ff, res_ff, res_in;
   logic [127:0] exp_ff;
   logic [5:0]   nv_ff;
   action_type   act_ff;
   logic         match_ff, match_in;
   logic [CntWidth-1:0] ad_cnt_ff, ad_cnt_in, msg_cnt_ff, msg_cnt_in;

   logic [255:0] mask, pblk, z, xr;
   logic [127:0] um0, um1, kn, tin;
   logic [127:0] upd [8];
   logic         do_upd;
   logic [5:0]   nclip;

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_write && !csr_index_hi) begin
         if (csr_index == 1'(CSR_KEY_LOW)) key_ff[63:0] <= csr_data;
         else                               key_ff[127:64] <= csr_data;
      end
   end

   // captured request word
   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= ACT_RSVD7;
      end else if (cmd.load) begin
         act_ff <= action_type'(req_action);
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         blk_ff <= {req_data_word3, req_data_word2, req_data_word1, req_data_word0};
         exp_ff <= {req_data_word1, req_data_word0};
         nv_ff  <= req_valid_bytes;
      end
   end

   assign nclip = (nv_ff > 6'd32) ? 6'd32 : nv_ff;
   assign status.action       = act_ff;
   assign status.data_nonzero = (nclip != 6'd0);

   // zero-padding and keystream
   always_comb begin
      for (int i = 0; i < 32; i++) begin
         mask[8*i +: 8] = (6'(i) < nclip) ? 8'hff : 8'h00;
      end
   end
   assign pblk = blk_ff & mask;
   assign z    = {s_ff[2] ^ s_ff[5] ^ (s_ff[6] & s_ff[7]),
                  s_ff[6] ^ s_ff[1] ^ (s_ff[2] & s_ff[3])};
   assign xr   = (pblk ^ z) & mask;
   assign kn   = key_ff ^ blk_ff[127:0];
   // bit lengths of AD and message
   assign tin  = {msg_cnt_ff, 3'b000, ad_cnt_ff, 3'b000} ^ s_ff[2];

   // round message select
   always_comb begin
      um0 = m0_ff;
      um1 = m1_ff;
      if (cmd.data_step) begin
         if (act_ff == ACT_DECRYPT) begin
            um0 = xr[127:0];
            um1 = xr[255:128];
         end else begin
            um0 = pblk[127:0];
            um1 = pblk[255:128];
         end
      end
   end

   // eight parallel AES rounds
   always_comb begin
      upd[0] = aes_round(s_ff[7], s_ff[0] ^ um0);
      upd[1] = aes_round(s_ff[0], s_ff[1]);
      upd[2] = aes_round(s_ff[1], s_ff[2]);
      upd[3] = aes_round(s_ff[2], s_ff[3]);
      upd[4] = aes_round(s_ff[3], s_ff[4] ^ um1);
      upd[5] = aes_round(s_ff[4], s_ff[5]);
      upd[6] = aes_round(s_ff[5], s_ff[6]);
      upd[7] = aes_round(s_ff[6], s_ff[7]);
   end

   assign do_upd = cmd.step || cmd.data_step;

   // state next value
   always_comb begin
      for (int i = 0; i < 8; i++) s_in[i] = do_upd ? upd[i] : s_ff[i];
      m0_in = m0_ff;
      m1_in = m1_ff;
      if (cmd.start_init) begin
         s_in[0] = kn;
         s_in[1] = Const1;
         s_in[2] = Const0;
         s_in[3] = Const1;
         s_in[4] = kn;
         s_in[5] = key_ff ^ Const0;
         s_in[6] = key_ff ^ Const1;
         s_in[7] = key_ff ^ Const0;
         m0_in   = blk_ff[127:0];
         m1_in   = key_ff;
      end else if (cmd.start_fin) begin
         m0_in = tin;
         m1_in = tin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) s_ff[i] <= '0;
      end else begin
         for (int i = 0; i < 8; i++) s_ff[i] <= s_in[i];
      end
   end
   always_ff @(posedge clock) begin
      m0_ff <= m0_in;
      m1_ff <= m1_in;
   end

   // byte counters
   always_comb begin
      ad_cnt_in  = ad_cnt_ff;
      msg_cnt_in = msg_cnt_ff;
      if (cmd.start_init) begin
         ad_cnt_in  = '0;
         msg_cnt_in = '0;
      end else if (cmd.data_step) begin
         if (act_ff == ACT_ABSORB) ad_cnt_in = ad_cnt_ff + CntWidth'(nclip);
         else                      msg_cnt_in = msg_cnt_ff + CntWidth'(nclip);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         ad_cnt_ff  <= '0;
         msg_cnt_ff <= '0;
      end else begin
         ad_cnt_ff  <= ad_cnt_in;
         msg_cnt_ff <= msg_cnt_in;
      end
   end

   // result word
   always_comb begin
      res_in   = res_ff;
      match_in = match_ff;
      if (cmd.clear_res) begin
         res_in   = '0;
         match_in = 1'b0;
         if (cmd.data_step && act_ff != ACT_ABSORB) res_in = xr;
      end else if (cmd.make_tag) begin
         // tag is taken from the last round's output, see upd
         res_in   = {128'd0, upd[0] ^ upd[1] ^ upd[2] ^ upd[3] ^ upd[4] ^ upd[5] ^ upd[6]};
         match_in = (act_ff == ACT_VERIFY) &&
                    ((upd[0] ^ upd[1] ^ upd[2] ^ upd[3] ^ upd[4] ^ upd[5] ^ upd[6]) == exp_ff);
      end
   end
   always_ff @(posedge clock) begin
      res_ff   <= res_in;
      match_ff <= match_in;
   end

   assign rsp_out_word0 = res_ff[63:0];
   assign rsp_out_word1 = res_ff[127:64];
   assign rsp_out_word2 = res_ff[191:128];
   assign rsp_out_word3 = res_ff[255:192];
   assign rsp_tag_match = match_ff;

endmodule
`default_nettype wire

FILE: src/aegis128l_aead_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aegis128l_aead_engine
// AEGIS-128L authenticated encryption engine, one action per request word.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   action, data_word0..3, valid_bytes
//  rsp      out        rsp_valid/rsp_stall   out_word0..3, tag_match
//  csr      in         csr_write             csr_index, csr_data (key halves)
//
// Absorb/encrypt/decrypt: capture, one state update (none if empty), out.
// Init, finalize/verify: setup, update rounds on the single update unit.
// Synchronous reset clears state, counters and key; no clearing pass.
// One word in flight; req is stalled until the response is taken.
module aegis128l_aead_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_action,
   input  wire logic [63:0] req_data_word0,
   input  wire logic [63:0] req_data_word1,
   input  wire logic [63:0] req_data_word2,
   input  wire logic [63:0] req_data_word3,
   input  wire logic [5:0]  req_valid_bytes,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_out_word0,
   output logic [63:0]      rsp_out_word1,
   output logic [63:0]      rsp_out_word2,
   output logic [63:0]      rsp_out_word3,
   output logic             rsp_tag_match,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import aegis_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   aegis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   aegis_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_action      (req_action),
      .req_data_word0  (req_data_word0),
      .req_data_word1  (req_data_word1),
      .req_data_word2  (req_data_word2),
      .req_data_word3  (req_data_word3),
      .req_valid_bytes (req_valid_bytes),
      .csr_write       (csr_write),
      .csr_index       (csr_index[0:0]),
      .csr_index_hi    (csr_index[1]),
      .csr_data        (csr_data),
      .rsp_out_word0   (rsp_out_word0),
      .rsp_out_word1   (rsp_out_word1),
      .rsp_out_word2   (rsp_out_word2),
      .rsp_out_word3   (rsp_out_word3),
      .rsp_tag_match   (rsp_tag_match)
   );

endmodule
`default_nettype wire
